### sv/ted_pkg.sv
// Shared types and constants for the termcap escape decoder.
`timescale 1ns / 1ps

package ted_pkg;

    // Decode modes
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_SKIP   = 3'd1;
    localparam logic [2:0] MODE_BSL    = 3'd2;
    localparam logic [2:0] MODE_CARET  = 3'd3;
    localparam logic [2:0] MODE_OCTAL  = 3'd4;

    // Characters recognized in the entry text
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    // Decoded values of the escapes
    localparam logic [7:0] VAL_ESC = 8'd27;
    localparam logic [7:0] VAL_LF  = 8'd10;
    localparam logic [7:0] VAL_CR  = 8'd13;
    localparam logic [7:0] VAL_TAB = 8'd9;
    localparam logic [7:0] VAL_BS  = 8'd8;
    localparam logic [7:0] VAL_FF  = 8'd12;
    localparam logic [7:0] CTRL_BASE = 8'd64;   // 'A' - 1

    // Most result items one input item can cause
    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // Results of one decode pass
    typedef struct packed {
        t_out_item [MAX_RES-1:0] items;
        logic [1:0]              cnt;
    } t_dec;

endpackage

### sv/ted_decode.sv
// Decode logic: one raw byte plus current mode to up to three result items.
`timescale 1ns / 1ps

module ted_decode (
    input  ted_pkg::t_in_item i_item,
    input  logic [2:0]        i_mode,
    input  logic [7:0]        i_oct,
    output ted_pkg::t_dec     o_dec,
    output logic [2:0]        o_mode,
    output logic [7:0]        o_oct
);
    import ted_pkg::*;

    logic [7:0] b;
    t_dec       dec;
    logic [2:0] mode;
    logic [7:0] oct;

    assign b = i_item.in_byte;

    always_comb begin
        dec  = '0;
        mode = i_mode;
        oct  = i_oct;

        unique case (i_mode)
            MODE_SKIP: begin
                if (b != CH_SPACE && b != CH_TAB) begin
                    mode = MODE_NORMAL;
                end
            end
            MODE_BSL: begin
                mode = MODE_NORMAL;
                unique case (b)
                    CH_UP_E: begin dec.items[dec.cnt] = '{VAL_ESC, 1'b0}; dec.cnt += 2'd1; end
                    CH_LO_N: begin dec.items[dec.cnt] = '{VAL_LF, 1'b0};  dec.cnt += 2'd1; end
                    CH_LO_R: begin dec.items[dec.cnt] = '{VAL_CR, 1'b0};  dec.cnt += 2'd1; end
                    CH_LO_T: begin dec.items[dec.cnt] = '{VAL_TAB, 1'b0}; dec.cnt += 2'd1; end
                    CH_LO_B: begin dec.items[dec.cnt] = '{VAL_BS, 1'b0};  dec.cnt += 2'd1; end
                    CH_LO_F: begin dec.items[dec.cnt] = '{VAL_FF, 1'b0};  dec.cnt += 2'd1; end
                    CH_ZERO, CH_ONE: begin
                        oct  = {7'd0, b[0]};
                        mode = MODE_OCTAL;
                    end
                    default: begin
                        // pass the backslash, then decode the byte afresh
                        dec.items[dec.cnt] = '{CH_BSL, 1'b0};
                        dec.cnt += 2'd1;
                    end
                endcase
            end
            MODE_CARET: begin
                if (b >= CH_UP_A && b <= CH_UP_Z) begin
                    dec.items[dec.cnt] = '{b - CTRL_BASE, 1'b0};
                    dec.cnt += 2'd1;
                    mode = MODE_NORMAL;
                end else begin
                    dec.items[dec.cnt] = '{CH_CARET, 1'b0};
                    dec.cnt += 2'd1;
                    mode = MODE_NORMAL;
                end
            end
            MODE_OCTAL: begin
                if (b >= CH_ZERO && b <= CH_SEVEN) begin
                    // value * 8 + digit, kept to eight bits
                    oct = {i_oct[4:0], b[2:0]};
                end else begin
                    dec.items[dec.cnt] = '{i_oct, 1'b0};
                    dec.cnt += 2'd1;
                    oct  = '0;
                    mode = MODE_NORMAL;
                end
            end
            default: mode = MODE_NORMAL;
        endcase

        // Decode the byte afresh where the mode dropped back to normal
        if (mode == MODE_NORMAL && !(i_mode == MODE_BSL && dec.cnt != 2'd0
                && dec.items[0].out_byte != CH_BSL)
                && !(i_mode == MODE_CARET && b >= CH_UP_A && b <= CH_UP_Z)) begin
            priority if (b == CH_BSL) begin
                mode = MODE_BSL;
            end else if (b == CH_CARET) begin
                mode = MODE_CARET;
            end else if (b == CH_COLON) begin
                dec.items[dec.cnt] = '{b, 1'b0};
                dec.cnt += 2'd1;
                mode = MODE_SKIP;
            end else begin
                dec.items[dec.cnt] = '{b, 1'b0};
                dec.cnt += 2'd1;
            end
        end

        // Flush anything pending and close the entry
        if (i_item.in_last) begin
            priority if (mode == MODE_BSL) begin
                dec.items[dec.cnt] = '{CH_BSL, 1'b0};
                dec.cnt += 2'd1;
            end else if (mode == MODE_CARET) begin
                dec.items[dec.cnt] = '{CH_CARET, 1'b0};
                dec.cnt += 2'd1;
            end else if (mode == MODE_OCTAL) begin
                dec.items[dec.cnt] = '{oct, 1'b0};
                dec.cnt += 2'd1;
            end
            dec.items[dec.cnt] = '{CH_COLON, 1'b1};
            dec.cnt += 2'd1;
            mode = MODE_NORMAL;
            oct  = '0;
        end
    end

    assign o_dec  = dec;
    assign o_mode = mode;
    assign o_oct  = oct;

endmodule

### sv/ted_outbuf.sv
// Result register: holds the items of one decode pass and hands them out in order.
`timescale 1ns / 1ps

module ted_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ted_pkg::t_dec      i_dec,
    input  logic               i_ready,
    output logic               o_free,
    output logic               o_valid,
    output ted_pkg::t_out_item o_item
);
    import ted_pkg::*;

    t_out_item [MAX_RES-1:0] r_items;
    logic [1:0]              r_cnt;
    logic [1:0]              r_idx;
    logic                    take;

    assign o_valid = (r_idx != r_cnt);
    assign take    = o_valid && i_ready;
    assign o_free  = !o_valid || (take && (r_idx + 2'd1 == r_cnt));
    assign o_item  = r_items[r_idx];

    // Hold the item payloads
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_items <= i_dec.items;
        end
    end

    // Load a new set or advance the read index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_dec.cnt;
            r_idx <= '0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

### sv/termcap_escape_decoder.sv
// Top level of the termcap escape decoder.
`timescale 1ns / 1ps
// Decodes the raw text of one termcap entry, one byte per item, into the
// bytes of the stripped entry: backslash escapes, octal runs, caret control
// codes and blanks after colons are resolved. The byte flagged in_last ends
// the entry; anything pending is flushed and a closing colon with out_last
// set is appended.
// Input channel: i_valid / o_ready carry i_item. Output channel:
// o_valid / i_ready carry o_item. Both are valid/ready handshakes.
// An input item is decoded in the cycle it is accepted and its zero to three
// result items land in the result register; the first is offered in the
// cycle after acceptance. The result register hands out one item per cycle
// while i_ready is high; an item holds it until all its results have left,
// so the decoder takes one item per cycle only while each causes one result at most.
// The next item is taken in the same cycle the last buffered result leaves.
// When the receiver stalls, results hold and o_ready drops once the buffered
// set cannot drain this cycle. Synchronous reset returns the mode to normal,
// clears the octal value and empties the result register.
module termcap_escape_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ted_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output ted_pkg::t_out_item o_item
);
    import ted_pkg::*;

    logic [2:0] r_mode;
    logic [7:0] r_oct;
    logic [2:0] n_mode;
    logic [7:0] n_oct;
    t_dec       dec;
    logic       free;
    logic       accept;

    assign o_ready = free;
    assign accept  = i_valid && free;

    ted_decode u_decode (
        .i_item (i_item),
        .i_mode (r_mode),
        .i_oct  (r_oct),
        .o_dec  (dec),
        .o_mode (n_mode),
        .o_oct  (n_oct)
    );

    ted_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_dec   (dec),
        .i_ready (i_ready),
        .o_free  (free),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    // Advance decode state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_oct  <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_oct  <= n_oct;
        end
    end

    // The end of an entry always yields at least the closing colon
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.in_last |=> o_valid)
        else $error("entry end produced no item");

    // The end of an entry leaves the decoder in its reset state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.in_last |=> r_mode == MODE_NORMAL && r_oct == 8'd0)
        else $error("decode state not cleared at entry end");

    // An octal digit inside a run emits nothing
    a_octal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_mode == MODE_OCTAL && !i_item.in_last
        && i_item.in_byte >= CH_ZERO && i_item.in_byte <= CH_SEVEN |=> !o_valid)
        else $error("octal digit produced an item");

endmodule
